[rtl/core/pseq_pkg.sv]
// Shared types, codes and helpers of the pulse sequencer.
`timescale 1ns / 1ps
`default_nettype none

package pseq_pkg;

    typedef enum logic [4:0] {
        MODE_IDLE     = 5'b00001,
        MODE_LIVE     = 5'b00010,
        MODE_SHUTTING = 5'b00100,
        MODE_SHUT     = 5'b01000,
        MODE_FAULT    = 5'b10000
    } mode_t;

    localparam logic [1:0] DES_IDLE     = 2'd0;
    localparam logic [1:0] DES_LIVE     = 2'd1;
    localparam logic [1:0] DES_SHUTDOWN = 2'd2;
    localparam logic [1:0] DES_CHECKS   = 2'd3;

    localparam logic [2:0] STATE_IDLE     = 3'd0;
    localparam logic [2:0] STATE_LIVE     = 3'd1;
    localparam logic [2:0] STATE_SHUTTING = 3'd2;
    localparam logic [2:0] STATE_SHUT     = 3'd3;
    localparam logic [2:0] STATE_FAULT    = 3'd4;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_CHECKS   = 2'd1;
    localparam logic [1:0] ERR_MISMATCH = 2'd2;

    localparam logic [2:0] REG_ON_TIME_A    = 3'd0;
    localparam logic [2:0] REG_ON_TIME_B    = 3'd1;
    localparam logic [2:0] REG_OFF_TIME_A   = 3'd2;
    localparam logic [2:0] REG_OFF_TIME_B   = 3'd3;
    localparam logic [2:0] REG_SAFE_VOLTAGE = 3'd4;

    localparam int ADDR_BITS  = 5;
    localparam int APB_WIDTH  = 32;
    localparam int OUT_FIELDS = 6;
    localparam int OUT_WIDTH  = 8;

    typedef struct packed {
        logic [1:0] error_code;
        logic [2:0] actual_state;
        logic       switch_on;
    } result_t;

    function automatic logic [2:0] state_code(input mode_t mode);
        logic [2:0] code;
        begin
            unique case (mode)
                MODE_IDLE:     code = STATE_IDLE;
                MODE_LIVE:     code = STATE_LIVE;
                MODE_SHUTTING: code = STATE_SHUTTING;
                MODE_SHUT:     code = STATE_SHUT;
                MODE_FAULT:    code = STATE_FAULT;
                default:       code = STATE_IDLE;
            endcase
            return code;
        end
    endfunction

endpackage

`default_nettype wire

[rtl/core/hv_supply_pulse_sequencer_top.sv]
// Top level of the pulse sequencer: stream registers, configuration and core.
`timescale 1ns / 1ps
`default_nettype none

// Each input transaction is one microsecond tick and produces exactly one result
// transaction. A tick is captured in the input register, the core updates its
// state and computes the result in one step, and the result register holds it
// for the output side until it is taken. One tick is taken in every clock cycle
// while the output side keeps up. Configuration registers are written through
// the APB-style port and are to be changed only while no tick is in flight.
module hv_supply_pulse_sequencer_top #(
    parameter int TIME_BITS    = 20,
    parameter int VOLTAGE_BITS = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // Fields from bit 0: desired_state[2], output_threshold_hit,
    // first_stage_threshold_hit, checks_passed, sample_valid, output_voltage.
    input  wire logic [((6 + VOLTAGE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // Fields from bit 0: switch_on, actual_state[3], error_code[2].
    output logic      [pseq_pkg::OUT_WIDTH-1:0]        m_tdata,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [pseq_pkg::ADDR_BITS-1:0]        paddr,
    input  wire logic [pseq_pkg::APB_WIDTH-1:0]        pwdata,
    output logic      [pseq_pkg::APB_WIDTH-1:0]        prdata,
    output logic                                       pready
);

    localparam int IN_FIELDS = 6 + VOLTAGE_BITS;

    logic                    in_valid_reg;
    logic [IN_FIELDS-1:0]    in_data_reg;
    logic                    out_valid_reg;
    pseq_pkg::result_t       out_data_reg;
    logic                    advance;
    pseq_pkg::result_t       core_result;
    logic [TIME_BITS-1:0]    on_time_a;
    logic [TIME_BITS-1:0]    on_time_b;
    logic [TIME_BITS-1:0]    off_time_a;
    logic [TIME_BITS-1:0]    off_time_b;
    logic [VOLTAGE_BITS-1:0] safe_voltage;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata[IN_FIELDS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= core_result;
        end
    end

    pseq_cfg_regs #(
        .TIME_BITS    (TIME_BITS),
        .VOLTAGE_BITS (VOLTAGE_BITS)
    ) u_cfg_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .on_time_a    (on_time_a),
        .on_time_b    (on_time_b),
        .off_time_a   (off_time_a),
        .off_time_b   (off_time_b),
        .safe_voltage (safe_voltage)
    );

    pseq_core #(
        .TIME_BITS    (TIME_BITS),
        .VOLTAGE_BITS (VOLTAGE_BITS)
    ) u_core (
        .clk                       (clk),
        .rst_n                     (rst_n),
        .step                      (advance),
        .desired_state             (in_data_reg[1:0]),
        .output_threshold_hit      (in_data_reg[2]),
        .first_stage_threshold_hit (in_data_reg[3]),
        .checks_passed             (in_data_reg[4]),
        .sample_valid              (in_data_reg[5]),
        .output_voltage            (in_data_reg[IN_FIELDS-1:6]),
        .on_time_a                 (on_time_a),
        .on_time_b                 (on_time_b),
        .off_time_a                (off_time_a),
        .off_time_b                (off_time_b),
        .safe_voltage              (safe_voltage),
        .result                    (core_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(pseq_pkg::OUT_WIDTH - pseq_pkg::OUT_FIELDS){1'b0}}, out_data_reg};

endmodule

`default_nettype wire

[rtl/core/pseq_cfg_regs.sv]
// Configuration register file with its APB-style access port.
`timescale 1ns / 1ps
`default_nettype none

module pseq_cfg_regs #(
    parameter int TIME_BITS    = 20,
    parameter int VOLTAGE_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [pseq_pkg::ADDR_BITS-1:0]      paddr,
    input  wire logic [pseq_pkg::APB_WIDTH-1:0]      pwdata,
    output logic      [pseq_pkg::APB_WIDTH-1:0]      prdata,
    output logic                                     pready,
    output logic      [TIME_BITS-1:0]                on_time_a,
    output logic      [TIME_BITS-1:0]                on_time_b,
    output logic      [TIME_BITS-1:0]                off_time_a,
    output logic      [TIME_BITS-1:0]                off_time_b,
    output logic      [VOLTAGE_BITS-1:0]             safe_voltage
);

    logic [TIME_BITS-1:0]    on_time_a_reg;
    logic [TIME_BITS-1:0]    on_time_b_reg;
    logic [TIME_BITS-1:0]    off_time_a_reg;
    logic [TIME_BITS-1:0]    off_time_b_reg;
    logic [VOLTAGE_BITS-1:0] safe_voltage_reg;
    logic                    write_en;
    logic [2:0]              reg_index;

    assign pready    = 1'b1;
    assign write_en  = psel && penable && pwrite && pready;
    assign reg_index = paddr[pseq_pkg::ADDR_BITS-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_time_a_reg    <= TIME_BITS'(10);
            on_time_b_reg    <= TIME_BITS'(10);
            off_time_a_reg   <= TIME_BITS'(90);
            off_time_b_reg   <= TIME_BITS'(90);
            safe_voltage_reg <= '0;
        end
        else if (write_en)
        begin
            unique case (reg_index)
                pseq_pkg::REG_ON_TIME_A:    on_time_a_reg    <= pwdata[TIME_BITS-1:0];
                pseq_pkg::REG_ON_TIME_B:    on_time_b_reg    <= pwdata[TIME_BITS-1:0];
                pseq_pkg::REG_OFF_TIME_A:   off_time_a_reg   <= pwdata[TIME_BITS-1:0];
                pseq_pkg::REG_OFF_TIME_B:   off_time_b_reg   <= pwdata[TIME_BITS-1:0];
                pseq_pkg::REG_SAFE_VOLTAGE: safe_voltage_reg <= pwdata[VOLTAGE_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            pseq_pkg::REG_ON_TIME_A:    prdata = pseq_pkg::APB_WIDTH'(on_time_a_reg);
            pseq_pkg::REG_ON_TIME_B:    prdata = pseq_pkg::APB_WIDTH'(on_time_b_reg);
            pseq_pkg::REG_OFF_TIME_A:   prdata = pseq_pkg::APB_WIDTH'(off_time_a_reg);
            pseq_pkg::REG_OFF_TIME_B:   prdata = pseq_pkg::APB_WIDTH'(off_time_b_reg);
            pseq_pkg::REG_SAFE_VOLTAGE: prdata = pseq_pkg::APB_WIDTH'(safe_voltage_reg);
            default:                    prdata = '0;
        endcase
    end

    assign on_time_a    = on_time_a_reg;
    assign on_time_b    = on_time_b_reg;
    assign off_time_a   = off_time_a_reg;
    assign off_time_b   = off_time_b_reg;
    assign safe_voltage = safe_voltage_reg;

endmodule

`default_nettype wire

[rtl/core/pseq_core.sv]
// Sequencer state and the per-tick update of mode, phase timer and switch drive.
`timescale 1ns / 1ps
`default_nettype none

module pseq_core #(
    parameter int TIME_BITS    = 20,
    parameter int VOLTAGE_BITS = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     step,
    input  wire logic [1:0]               desired_state,
    input  wire logic                     output_threshold_hit,
    input  wire logic                     first_stage_threshold_hit,
    input  wire logic                     checks_passed,
    input  wire logic                     sample_valid,
    input  wire logic [VOLTAGE_BITS-1:0]  output_voltage,
    input  wire logic [TIME_BITS-1:0]     on_time_a,
    input  wire logic [TIME_BITS-1:0]     on_time_b,
    input  wire logic [TIME_BITS-1:0]     off_time_a,
    input  wire logic [TIME_BITS-1:0]     off_time_b,
    input  wire logic [VOLTAGE_BITS-1:0]  safe_voltage,
    output pseq_pkg::result_t             result
);

    pseq_pkg::mode_t      mode_reg;
    pseq_pkg::mode_t      mode_next;
    logic                 in_on_phase_reg;
    logic                 in_on_phase_next;
    logic [TIME_BITS-1:0] phase_count_reg;
    logic [TIME_BITS-1:0] phase_count_next;
    logic                 gate_enabled_reg;
    logic                 gate_enabled_next;
    logic                 shutdown_latched_reg;
    logic                 shutdown_latched_next;
    logic [TIME_BITS-1:0] on_len;
    logic [TIME_BITS-1:0] off_len;
    logic                 switch_drive;
    logic [1:0]           error_code;

    function automatic logic [TIME_BITS-1:0] shorter(
        input logic [TIME_BITS-1:0] a,
        input logic [TIME_BITS-1:0] b
    );
        logic [TIME_BITS-1:0] m;
        begin
            m = (a < b) ? a : b;
            return (m == '0) ? TIME_BITS'(1) : m;
        end
    endfunction

    assign on_len  = shorter(on_time_a, on_time_b);
    assign off_len = shorter(off_time_a, off_time_b);

    always_comb
    begin
        mode_next             = mode_reg;
        in_on_phase_next      = in_on_phase_reg;
        phase_count_next      = phase_count_reg;
        gate_enabled_next     = gate_enabled_reg;
        shutdown_latched_next = shutdown_latched_reg ||
                                (desired_state == pseq_pkg::DES_SHUTDOWN);
        switch_drive          = 1'b0;
        error_code            = pseq_pkg::ERR_NONE;

        if (mode_reg == pseq_pkg::MODE_FAULT)
        begin
            error_code = pseq_pkg::ERR_MISMATCH;
        end
        else if (shutdown_latched_next)
        begin
            in_on_phase_next  = 1'b0;
            phase_count_next  = '0;
            gate_enabled_next = 1'b0;
            if (mode_reg != pseq_pkg::MODE_SHUT)
            begin
                mode_next = pseq_pkg::MODE_SHUTTING;
            end
            if (sample_valid)
            begin
                mode_next = (output_voltage <= safe_voltage) ? pseq_pkg::MODE_SHUT
                                                             : pseq_pkg::MODE_SHUTTING;
            end
        end
        else
        begin
            if (mode_reg != pseq_pkg::MODE_LIVE)
            begin
                mode_next         = pseq_pkg::MODE_IDLE;
                in_on_phase_next  = 1'b0;
                phase_count_next  = '0;
                gate_enabled_next = 1'b0;
                if (desired_state == pseq_pkg::DES_CHECKS)
                begin
                    if (!checks_passed)
                    begin
                        error_code = pseq_pkg::ERR_CHECKS;
                    end
                end
                else if (desired_state == pseq_pkg::DES_LIVE)
                begin
                    if (!checks_passed)
                    begin
                        error_code = pseq_pkg::ERR_CHECKS;
                    end
                    else if (on_time_a != on_time_b)
                    begin
                        mode_next  = pseq_pkg::MODE_FAULT;
                        error_code = pseq_pkg::ERR_MISMATCH;
                    end
                    else
                    begin
                        mode_next = pseq_pkg::MODE_LIVE;
                    end
                end
            end

            if (mode_next == pseq_pkg::MODE_LIVE)
            begin
                // A new on phase starts when the off phase has run out.
                if (!in_on_phase_next && phase_count_next == '0)
                begin
                    gate_enabled_next = !(output_threshold_hit || first_stage_threshold_hit);
                    in_on_phase_next  = 1'b1;
                    phase_count_next  = on_len;
                end
                if (in_on_phase_next)
                begin
                    switch_drive     = gate_enabled_next;
                    phase_count_next = phase_count_next - TIME_BITS'(1);
                    if (phase_count_next == '0)
                    begin
                        gate_enabled_next = 1'b0;
                        in_on_phase_next  = 1'b0;
                        if (desired_state != pseq_pkg::DES_LIVE)
                        begin
                            mode_next = pseq_pkg::MODE_IDLE;
                        end
                        else
                        begin
                            phase_count_next = off_len;
                        end
                    end
                end
                else
                begin
                    phase_count_next = phase_count_next - TIME_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg             <= pseq_pkg::MODE_IDLE;
            in_on_phase_reg      <= 1'b0;
            phase_count_reg      <= '0;
            gate_enabled_reg     <= 1'b0;
            shutdown_latched_reg <= 1'b0;
        end
        else if (step)
        begin
            mode_reg             <= mode_next;
            in_on_phase_reg      <= in_on_phase_next;
            phase_count_reg      <= phase_count_next;
            gate_enabled_reg     <= gate_enabled_next;
            shutdown_latched_reg <= shutdown_latched_next;
        end
    end

    assign result.switch_on    = switch_drive;
    assign result.actual_state = pseq_pkg::state_code(mode_next);
    assign result.error_code   = error_code;

endmodule

`default_nettype wire

[rtl/core/pseq_checker.sv]
// Port-level assertions for the pulse sequencer and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

module pseq_checker #(
    parameter int TIME_BITS    = 20,
    parameter int VOLTAGE_BITS = 16
) (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [pseq_pkg::OUT_WIDTH-1:0]   m_tdata,
    input wire logic                             psel,
    input wire logic                             penable,
    input wire logic                             pwrite,
    input wire logic [pseq_pkg::ADDR_BITS-1:0]   paddr,
    input wire logic [pseq_pkg::APB_WIDTH-1:0]   pwdata,
    input wire logic [pseq_pkg::APB_WIDTH-1:0]   prdata,
    input wire logic                             pready
);

    // A stalled result stays in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A fault keeps the switch off and reports the on-time mismatch.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3:1] == pseq_pkg::STATE_FAULT |->
            !m_tdata[0] && m_tdata[5:4] == pseq_pkg::ERR_MISMATCH)
        else $error("fault result with switch on or wrong error");

    // The switch conducts only while the pulse train runs, which can report idle on the
    // tick whose on phase ends the train, and never with an error.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |->
            (m_tdata[3:1] == pseq_pkg::STATE_LIVE || m_tdata[3:1] == pseq_pkg::STATE_IDLE) &&
            m_tdata[5:4] == pseq_pkg::ERR_NONE)
        else $error("switch on outside live mode");

    // Failed checks are reported only from the idle state.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[5:4] == pseq_pkg::ERR_CHECKS |->
            m_tdata[3:1] == pseq_pkg::STATE_IDLE && !m_tdata[0])
        else $error("checks error outside idle");

    // A write to on-time A is read back on the next cycle if the address still selects it.
    assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready &&
            paddr[pseq_pkg::ADDR_BITS-1:2] == pseq_pkg::REG_ON_TIME_A |=>
            paddr[pseq_pkg::ADDR_BITS-1:2] != pseq_pkg::REG_ON_TIME_A ||
            prdata[TIME_BITS-1:0] == $past(pwdata[TIME_BITS-1:0]))
        else $error("on-time readback mismatch");

endmodule

bind hv_supply_pulse_sequencer_top pseq_checker #(
    .TIME_BITS    (TIME_BITS),
    .VOLTAGE_BITS (VOLTAGE_BITS)
) u_pseq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
);

`default_nettype wire
